[sv/assert_macros.svh]
// assertion macros shared by the calendar time set editor rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold whenever the antecedent holds, same edge
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[sv/cte_pkg.sv]
// package for the calendar time set editor: key codes, field codes, limits
// and the month length function; no dependencies
package cte_pkg;

  // key and load codes carried in func
  typedef enum logic [2:0] {
    FUNC_LEFT  = 3'd0,
    FUNC_RIGHT = 3'd1,
    FUNC_DOWN  = 3'd2,
    FUNC_UP    = 3'd3,
    FUNC_SET   = 3'd4,
    FUNC_LOAD  = 3'd5
  } func_t;

  // selectable time fields
  typedef enum logic [2:0] {
    ITEM_YEAR    = 3'd0,
    ITEM_MONTH   = 3'd1,
    ITEM_DAY     = 3'd2,
    ITEM_WEEKDAY = 3'd3,
    ITEM_HOUR    = 3'd4,
    ITEM_MINUTE  = 3'd5,
    ITEM_SECOND  = 3'd6
  } item_t;

  // field limits on a common 7-bit scale
  localparam logic [6:0] YEAR_MAX    = 7'd99;
  localparam logic [6:0] MONTH_MIN   = 7'd1;
  localparam logic [6:0] MONTH_MAX   = 7'd12;
  localparam logic [6:0] DAY_MIN     = 7'd1;
  localparam logic [6:0] WEEKDAY_MIN = 7'd1;
  localparam logic [6:0] WEEKDAY_MAX = 7'd7;
  localparam logic [6:0] HOUR_MAX    = 7'd23;
  localparam logic [6:0] MINSEC_MAX  = 7'd59;
  localparam logic [6:0] ZERO_MIN    = 7'd0;

  // one result item
  typedef struct packed {
    logic       editing;
    logic [2:0] item;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       commit;
  } result_t;

  // days in month for year 2000+yr; 2100 (yr 100) is the only
  // century year in reach that is not a leap year
  function automatic logic [4:0] month_len(input logic [6:0] yr, input logic [3:0] mo);
    logic leap;
    leap = (yr[1:0] == 2'b00) && (yr != 7'd100);
    case (mo)
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      4'd2:                    month_len = leap ? 5'd29 : 5'd28;
      default:                 month_len = 5'd31;
    endcase
  endfunction

  // step up with wrap to lo when at or above hi or below lo
  function automatic logic [6:0] wrap_up(input logic [6:0] v, input logic [6:0] lo,
                                         input logic [6:0] hi);
    wrap_up = (v >= hi || v < lo) ? lo : v + 7'd1;
  endfunction

  // step down with wrap to hi when at or below lo or above hi
  function automatic logic [6:0] wrap_down(input logic [6:0] v, input logic [6:0] lo,
                                           input logic [6:0] hi);
    wrap_down = (v <= lo || v > hi) ? hi : v - 7'd1;
  endfunction

  // saturate into lo..hi
  function automatic logic [6:0] sat(input logic [6:0] v, input logic [6:0] lo,
                                     input logic [6:0] hi);
    if (v < lo)      sat = lo;
    else if (v > hi) sat = hi;
    else             sat = v;
  endfunction

endpackage

[sv/cte_cmd_if.sv]
// command channel of the calendar time set editor: key or load per transaction
// depends on nothing
interface cte_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [6:0] new_year;
  logic [3:0] new_month;
  logic [4:0] new_day;
  logic [2:0] new_weekday;
  logic [4:0] new_hour;
  logic [5:0] new_minute;
  logic [5:0] new_second;

  modport source (
    output valid, func, new_year, new_month, new_day, new_weekday,
           new_hour, new_minute, new_second,
    input  ready
  );

  modport sink (
    input  valid, func, new_year, new_month, new_day, new_weekday,
           new_hour, new_minute, new_second,
    output ready
  );
endinterface

[sv/cte_status_if.sv]
// status channel of the calendar time set editor: edit state and time per transaction
// depends on nothing
interface cte_status_if;
  logic       valid;
  logic       ready;
  logic       editing;
  logic [2:0] item;
  logic [6:0] year;
  logic [3:0] month;
  logic [4:0] day;
  logic [2:0] weekday;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  logic       commit;

  modport source (
    output valid, editing, item, year, month, day, weekday, hour, minute,
           second, commit,
    input  ready
  );

  modport sink (
    input  valid, editing, item, year, month, day, weekday, hour, minute,
           second, commit,
    output ready
  );
endinterface

[sv/calendar_time_set_editor.sv]
// calendar time set editor top level: keypad edit state machine with skid output
// depends on cte_pkg, cte_cmd_if, cte_status_if and assert_macros.svh
//
// usage
//   cmd carries one key (left, right, down, up, set) or a time load per
//   transaction. status returns one transaction per command: edit flag,
//   selected field, the seven time fields after the update and a commit
//   pulse on the set key that leaves edit mode.
//   each result is registered into the output register, or into the skid
//   entry while status stalls. throughput: one command per cycle while
//   cmd.ready is high; the update is a single pass of wrap, clamp and
//   month length logic between the time registers. the output register
//   plus one skid entry let cmd take a new transaction while a result is
//   still waiting; cmd.ready drops only when both hold results, i.e. once
//   a command is taken into the skid entry while status stalls on a result.
//   reset (rst, synchronous) leaves edit mode, selects the year field,
//   sets the time to year 0, month 1, day 1, weekday 1, 00:00:00 and
//   empties both result slots.
`include "assert_macros.svh"

module calendar_time_set_editor (
  input  logic         clk,
  input  logic         rst,
  cte_cmd_if.sink      cmd,
  cte_status_if.source status
);

  // edit and time state
  logic       edit_active,   edit_active_next;
  logic [2:0] cursor,        cursor_next;
  logic [6:0] year_count,    year_next;
  logic [3:0] month_count,   month_next;
  logic [4:0] day_count,     day_next;
  logic [2:0] weekday_count, weekday_next;
  logic [4:0] hour_count,    hour_next;
  logic [5:0] minute_count,  minute_next;
  logic [5:0] second_count,  second_next;
  logic       commit_next;

  logic [4:0] cur_len;
  logic [4:0] new_len;
  logic       step;
  logic       step_up;

  // output register and skid entry
  cte_pkg::result_t result_next;
  cte_pkg::result_t out_data;
  cte_pkg::result_t skid_data;
  logic             out_valid;
  logic             skid_valid;

  logic cmd_take;
  logic out_free;

  assign cmd.ready = !skid_valid;
  assign cmd_take  = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || status.ready;

  assign cur_len = cte_pkg::month_len(year_count, month_count);
  assign step_up = (cmd.func == cte_pkg::FUNC_UP);
  assign step    = edit_active &&
                   (cmd.func == cte_pkg::FUNC_UP || cmd.func == cte_pkg::FUNC_DOWN);

  // next state for one command
  always_comb begin
    edit_active_next = edit_active;
    cursor_next      = cursor;
    year_next        = year_count;
    month_next       = month_count;
    day_next         = day_count;
    weekday_next     = weekday_count;
    hour_next        = hour_count;
    minute_next      = minute_count;
    second_next      = second_count;
    commit_next      = 1'b0;

    if (!edit_active) begin
      if (cmd.func == cte_pkg::FUNC_SET) begin
        edit_active_next = 1'b1;
        cursor_next      = cte_pkg::ITEM_YEAR;
      end else if (cmd.func == cte_pkg::FUNC_LOAD) begin
        year_next    = cte_pkg::sat(cmd.new_year, cte_pkg::ZERO_MIN, cte_pkg::YEAR_MAX);
        month_next   = 4'(cte_pkg::sat(7'(cmd.new_month), cte_pkg::MONTH_MIN,
                                       cte_pkg::MONTH_MAX));
        day_next     = (cmd.new_day == 5'd0) ? 5'(cte_pkg::DAY_MIN) : cmd.new_day;
        weekday_next = (cmd.new_weekday == 3'd0) ? 3'(cte_pkg::WEEKDAY_MIN)
                                                 : cmd.new_weekday;
        hour_next    = 5'(cte_pkg::sat(7'(cmd.new_hour), cte_pkg::ZERO_MIN,
                                       cte_pkg::HOUR_MAX));
        minute_next  = 6'(cte_pkg::sat(7'(cmd.new_minute), cte_pkg::ZERO_MIN,
                                       cte_pkg::MINSEC_MAX));
        second_next  = 6'(cte_pkg::sat(7'(cmd.new_second), cte_pkg::ZERO_MIN,
                                       cte_pkg::MINSEC_MAX));
      end
    end else begin
      case (cmd.func)
        cte_pkg::FUNC_LEFT: begin
          cursor_next = (cursor == cte_pkg::ITEM_YEAR || cursor > cte_pkg::ITEM_SECOND)
                        ? cte_pkg::ITEM_SECOND : cursor - 3'd1;
        end
        cte_pkg::FUNC_RIGHT: begin
          cursor_next = (cursor >= cte_pkg::ITEM_SECOND) ? cte_pkg::ITEM_YEAR
                                                         : cursor + 3'd1;
        end
        cte_pkg::FUNC_SET: begin
          edit_active_next = 1'b0;
          commit_next      = 1'b1;
        end
        default: begin
        end
      endcase

      // up or down on the selected field
      if (step) begin
        case (cursor)
          cte_pkg::ITEM_YEAR: begin
            year_next = step_up
              ? cte_pkg::wrap_up(year_count, cte_pkg::ZERO_MIN, cte_pkg::YEAR_MAX)
              : cte_pkg::wrap_down(year_count, cte_pkg::ZERO_MIN, cte_pkg::YEAR_MAX);
          end
          cte_pkg::ITEM_MONTH: begin
            month_next = 4'(step_up
              ? cte_pkg::wrap_up(7'(month_count), cte_pkg::MONTH_MIN, cte_pkg::MONTH_MAX)
              : cte_pkg::wrap_down(7'(month_count), cte_pkg::MONTH_MIN,
                                   cte_pkg::MONTH_MAX));
          end
          cte_pkg::ITEM_DAY: begin
            if (step_up) day_next = (day_count >= cur_len) ? 5'd1 : day_count + 5'd1;
            else         day_next = (day_count <= 5'd1) ? cur_len : day_count - 5'd1;
          end
          cte_pkg::ITEM_WEEKDAY: begin
            weekday_next = 3'(step_up
              ? cte_pkg::wrap_up(7'(weekday_count), cte_pkg::WEEKDAY_MIN,
                                 cte_pkg::WEEKDAY_MAX)
              : cte_pkg::wrap_down(7'(weekday_count), cte_pkg::WEEKDAY_MIN,
                                   cte_pkg::WEEKDAY_MAX));
          end
          cte_pkg::ITEM_HOUR: begin
            hour_next = 5'(step_up
              ? cte_pkg::wrap_up(7'(hour_count), cte_pkg::ZERO_MIN, cte_pkg::HOUR_MAX)
              : cte_pkg::wrap_down(7'(hour_count), cte_pkg::ZERO_MIN, cte_pkg::HOUR_MAX));
          end
          cte_pkg::ITEM_MINUTE: begin
            minute_next = 6'(step_up
              ? cte_pkg::wrap_up(7'(minute_count), cte_pkg::ZERO_MIN, cte_pkg::MINSEC_MAX)
              : cte_pkg::wrap_down(7'(minute_count), cte_pkg::ZERO_MIN,
                                   cte_pkg::MINSEC_MAX));
          end
          cte_pkg::ITEM_SECOND: begin
            second_next = 6'(step_up
              ? cte_pkg::wrap_up(7'(second_count), cte_pkg::ZERO_MIN, cte_pkg::MINSEC_MAX)
              : cte_pkg::wrap_down(7'(second_count), cte_pkg::ZERO_MIN,
                                   cte_pkg::MINSEC_MAX));
          end
          default: begin
          end
        endcase
      end
    end

    // year or month change pulls the day down to the new month length
    new_len = cte_pkg::month_len(year_next, month_next);
    if (step && (cursor == cte_pkg::ITEM_YEAR || cursor == cte_pkg::ITEM_MONTH) &&
        day_next > new_len) begin
      day_next = new_len;
    end

    result_next.editing = edit_active_next;
    result_next.item    = cursor_next;
    result_next.year    = year_next;
    result_next.month   = month_next;
    result_next.day     = day_next;
    result_next.weekday = weekday_next;
    result_next.hour    = hour_next;
    result_next.minute  = minute_next;
    result_next.second  = second_next;
    result_next.commit  = commit_next;
  end

  // state registers, updated once per accepted command
  always_ff @(posedge clk) begin
    if (rst) begin
      edit_active   <= 1'b0;
      cursor        <= cte_pkg::ITEM_YEAR;
      year_count    <= 7'd0;
      month_count   <= 4'd1;
      day_count     <= 5'd1;
      weekday_count <= 3'd1;
      hour_count    <= 5'd0;
      minute_count  <= 6'd0;
      second_count  <= 6'd0;
    end else if (cmd_take) begin
      edit_active   <= edit_active_next;
      cursor        <= cursor_next;
      year_count    <= year_next;
      month_count   <= month_next;
      day_count     <= day_next;
      weekday_count <= weekday_next;
      hour_count    <= hour_next;
      minute_count  <= minute_next;
      second_count  <= second_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (cmd_take) begin
        out_data  <= result_next;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (cmd_take) begin
      skid_data  <= result_next;
      skid_valid <= 1'b1;
    end
  end

  // status channel drive
  assign status.valid   = out_valid;
  assign status.editing = out_data.editing;
  assign status.item    = out_data.item;
  assign status.year    = out_data.year;
  assign status.month   = out_data.month;
  assign status.day     = out_data.day;
  assign status.weekday = out_data.weekday;
  assign status.hour    = out_data.hour;
  assign status.minute  = out_data.minute;
  assign status.second  = out_data.second;
  assign status.commit  = out_data.commit;

  // assertions
  `ASSERT_IMPLIES(a_skid_needs_out, clk, rst, skid_valid, out_valid,
                  "skid entry holds a result while the output register is empty")
  `ASSERT_IMPLIES(a_commit_leaves_edit, clk, rst, out_valid && out_data.commit,
                  !out_data.editing, "commit shown while still in edit mode")
  `ASSERT_ALWAYS(a_cursor_range, clk, rst, cursor <= cte_pkg::ITEM_SECOND,
                 "selected field beyond second")
  `ASSERT_ALWAYS(a_month_range, clk, rst, month_count >= 4'd1 && month_count <= 4'd12,
                 "month out of range")
  `ASSERT_IMPLIES(a_enter_at_year, clk, rst, $rose(edit_active),
                  cursor == cte_pkg::ITEM_YEAR, "edit mode entered away from year field")

endmodule

[sim/cte_edit_monitor.sv]
`timescale 1ns / 100ps
// status predictor and comparator for the calendar_time_set_editor regression
// depends on cte_pkg, cte_cmd_if and cte_status_if; watches both channels, drives neither
module cte_edit_monitor (
  input  logic  clk,
  input  logic  rst,
  cte_cmd_if    cmd,
  cte_status_if status,
  output int    fail_count,
  output int    pending
);
  import cte_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // predicted editor state
  logic       editing_now;
  item_t      cursor;
  logic [6:0] year_now;
  logic [3:0] month_now;
  logic [4:0] day_now;
  logic [2:0] weekday_now;
  logic [4:0] hour_now;
  logic [5:0] minute_now;
  logic [5:0] second_now;

  // predicted status transactions not yet delivered, oldest first
  result_t status_due_q[$];
  int      errors = 0;

  // days in month for year 2000+yr2, gregorian leap rule
  function automatic int month_days(input int yr2, input int mo);
    int full;
    full = 2000 + yr2;
    if (mo == 4 || mo == 6 || mo == 9 || mo == 11) return 30;
    if (mo != 2) return 31;
    if ((full % 4 == 0 && full % 100 != 0) || full % 400 == 0) return 29;
    return 28;
  endfunction

  // one step with wrap; out-of-range values land on lo going up and on hi going down
  function automatic int roll(input int v, input int lo, input int hi, input bit up);
    if (up) return (v >= hi || v < lo) ? lo : v + 1;
    return (v <= lo || v > hi) ? hi : v - 1;
  endfunction

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // pull the day back inside the current month
  function void clamp_day();
    int lim;
    lim = month_days(int'(year_now), int'(month_now));
    if (day_now > lim) day_now = 5'(lim);
  endfunction

  // up or down on the selected field
  function void step_selected(input bit up);
    int lim;
    lim = month_days(int'(year_now), int'(month_now));
    case (cursor)
      ITEM_YEAR: begin
        year_now = 7'(roll(int'(year_now), 0, 99, up));
        clamp_day();
      end
      ITEM_MONTH: begin
        month_now = 4'(roll(int'(month_now), 1, 12, up));
        clamp_day();
      end
      ITEM_DAY: begin
        // a loaded day may sit above the month length
        if (up) day_now = (day_now >= lim) ? 5'd1 : day_now + 5'd1;
        else    day_now = (day_now <= 1) ? 5'(lim) : day_now - 5'd1;
      end
      ITEM_WEEKDAY: weekday_now = 3'(roll(int'(weekday_now), 1, 7, up));
      ITEM_HOUR:    hour_now = 5'(roll(int'(hour_now), 0, 23, up));
      ITEM_MINUTE:  minute_now = 6'(roll(int'(minute_now), 0, 59, up));
      ITEM_SECOND:  second_now = 6'(roll(int'(second_now), 0, 59, up));
      default: ;
    endcase
  endfunction

  // apply one command and return the status it should produce
  function automatic result_t advance_time_setting(
    input logic [2:0] f, input logic [6:0] y, input logic [3:0] m, input logic [4:0] d,
    input logic [2:0] w, input logic [4:0] h, input logic [5:0] mi, input logic [5:0] s);
    result_t r;
    logic    commit_now;
    commit_now = 1'b0;
    if (!editing_now) begin
      if (f == FUNC_SET) begin
        editing_now = 1'b1;
        cursor = ITEM_YEAR;
      end else if (f == FUNC_LOAD) begin
        year_now    = 7'(clip(int'(y), 0, 99));
        month_now   = 4'(clip(int'(m), 1, 12));
        day_now     = 5'(clip(int'(d), 1, 31));
        weekday_now = 3'(clip(int'(w), 1, 7));
        hour_now    = 5'(clip(int'(h), 0, 23));
        minute_now  = 6'(clip(int'(mi), 0, 59));
        second_now  = 6'(clip(int'(s), 0, 59));
      end
    end else begin
      case (f)
        FUNC_LEFT:  cursor = (cursor == ITEM_YEAR) ? ITEM_SECOND : item_t'(cursor - 1);
        FUNC_RIGHT: cursor = (cursor == ITEM_SECOND) ? ITEM_YEAR : item_t'(cursor + 1);
        FUNC_DOWN:  step_selected(1'b0);
        FUNC_UP:    step_selected(1'b1);
        FUNC_SET: begin
          editing_now = 1'b0;
          commit_now = 1'b1;
        end
        default: ;
      endcase
    end
    r.editing = editing_now;
    r.item    = cursor;
    r.year    = year_now;
    r.month   = month_now;
    r.day     = day_now;
    r.weekday = weekday_now;
    r.hour    = hour_now;
    r.minute  = minute_now;
    r.second  = second_now;
    r.commit  = commit_now;
    return r;
  endfunction

  function void note_field(input string name, input logic [6:0] got, input logic [6:0] want);
    if (got !== want) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("status %s mismatch: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : track
    result_t want;
    if (rst) begin
      editing_now = 1'b0;
      cursor      = ITEM_YEAR;
      year_now    = 7'd0;
      month_now   = 4'd1;
      day_now     = 5'd1;
      weekday_now = 3'd1;
      hour_now    = 5'd0;
      minute_now  = 6'd0;
      second_now  = 6'd0;
      status_due_q.delete();
    end else begin
      // compare a delivered status transaction with the oldest prediction
      if (status.valid && status.ready) begin
        if (status_due_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("status transaction with no command waiting for it");
        end else begin
          want = status_due_q.pop_front();
          note_field("editing", 7'(status.editing), 7'(want.editing));
          note_field("item", 7'(status.item), 7'(want.item));
          note_field("year", status.year, want.year);
          note_field("month", 7'(status.month), 7'(want.month));
          note_field("day", 7'(status.day), 7'(want.day));
          note_field("weekday", 7'(status.weekday), 7'(want.weekday));
          note_field("hour", 7'(status.hour), 7'(want.hour));
          note_field("minute", 7'(status.minute), 7'(want.minute));
          note_field("second", 7'(status.second), 7'(want.second));
          note_field("commit", 7'(status.commit), 7'(want.commit));
        end
      end
      // predict the status of an accepted command transaction
      if (cmd.valid && cmd.ready)
        status_due_q.push_back(advance_time_setting(cmd.func, cmd.new_year, cmd.new_month,
          cmd.new_day, cmd.new_weekday, cmd.new_hour, cmd.new_minute, cmd.new_second));
    end
    fail_count <= errors;
    pending <= status_due_q.size();
  end

endmodule

[sim/calendar_time_set_editor_test.sv]
`timescale 1ns / 100ps
// top of the calendar_time_set_editor regression: clock, reset, key and load stimulus,
// status back-pressure and verdict; depends on cte_pkg, both interfaces, the rtl and cte_edit_monitor
module calendar_time_set_editor_test;
  import cte_pkg::*;

  localparam logic [2:0] CODE_SPARE_LO = 3'd6;
  localparam logic [2:0] CODE_SPARE_HI = 3'd7;
  localparam int COMMAND_TARGET = 1300;
  localparam int STALL_LIMIT    = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 8;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   sent = 0;
  bit   in_edit = 1'b0;

  cte_cmd_if    cmd ();
  cte_status_if status ();

  calendar_time_set_editor dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status)
  );

  cte_edit_monitor monitor (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // offer one command transaction and wait until it is taken
  task automatic send_cmd(input logic [2:0] f, input logic [6:0] y, input logic [3:0] m,
                          input logic [4:0] d, input logic [2:0] w, input logic [4:0] h,
                          input logic [5:0] mi, input logic [5:0] s);
    int gap;
    // every 200 commands a stretch goes out with no gaps
    gap = (sent % 200 < 40) ? 0 : pick_gap();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.func        <= f;
    cmd.new_year    <= y;
    cmd.new_month   <= m;
    cmd.new_day     <= d;
    cmd.new_weekday <= w;
    cmd.new_hour    <= h;
    cmd.new_minute  <= mi;
    cmd.new_second  <= s;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    sent++;
    if (f == FUNC_SET) in_edit = !in_edit;
  endtask

  // command with random bits in every time field
  task automatic send_raw(input logic [2:0] f);
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    send_cmd(f, bits[6:0], bits[10:7], bits[15:11], bits[18:16], bits[23:19],
             bits[29:24], bits[35:30]);
  endtask

  task automatic send_load_in_range();
    send_cmd(FUNC_LOAD, 7'($urandom_range(0, 99)), 4'($urandom_range(1, 12)),
             5'($urandom_range(1, 31)), 3'($urandom_range(1, 7)),
             5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
             6'($urandom_range(0, 59)));
  endtask

  // key inside an edit session: mostly steps and moves, a little noise
  function automatic logic [2:0] pick_edit_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return FUNC_LEFT;
    if (r < 30) return FUNC_RIGHT;
    if (r < 60) return FUNC_DOWN;
    if (r < 90) return FUNC_UP;
    if (r < 95) return FUNC_LOAD;
    return (r < 98) ? CODE_SPARE_LO : CODE_SPARE_HI;
  endfunction

  // status side: random stalls, long open stretches, one long hold-off
  initial begin : status_sink
    int  run;
    int  gap;
    bit  held;
    held = 1'b0;
    status.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && sent >= 300) begin
        held = 1'b1;
        status.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      run = ($urandom_range(0, 9) < 2) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      status.ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        status.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // give up after a long stretch with no transaction on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd.valid && cmd.ready) || (status.valid && status.ready)) quiet = 0;
      else quiet++;
    end
    $display("calendar_time_set_editor regression: fail");
    $finish;
  end

  initial begin : stimulus
    int pick;
    int n;
    cmd.valid       <= 1'b0;
    cmd.func        <= FUNC_LEFT;
    cmd.new_year    <= '0;
    cmd.new_month   <= '0;
    cmd.new_day     <= '0;
    cmd.new_weekday <= '0;
    cmd.new_hour    <= '0;
    cmd.new_minute  <= '0;
    cmd.new_second  <= '0;
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // keys and spare codes while idle change nothing
    send_raw(FUNC_LEFT);
    send_raw(FUNC_RIGHT);
    send_raw(FUNC_DOWN);
    send_raw(FUNC_UP);
    send_raw(CODE_SPARE_LO);
    send_raw(CODE_SPARE_HI);
    // loads at the top of every range, above it, and all zeros
    send_cmd(FUNC_LOAD, 7'd99, 4'd12, 5'd31, 3'd7, 5'd23, 6'd59, 6'd59);
    send_cmd(FUNC_LOAD, 7'd127, 4'd15, 5'd31, 3'd7, 5'd31, 6'd63, 6'd63);
    send_cmd(FUNC_LOAD, 7'd0, 4'd0, 5'd0, 3'd0, 5'd0, 6'd0, 6'd0);
    // march 31 of a leap year, then walk into february and a plain year
    send_cmd(FUNC_LOAD, 7'd0, 4'd3, 5'd31, 3'd5, 5'd12, 6'd30, 6'd0);
    send_raw(FUNC_SET);
    send_raw(FUNC_LEFT);
    send_raw(FUNC_DOWN);
    send_raw(FUNC_RIGHT);
    send_raw(FUNC_RIGHT);
    send_raw(FUNC_DOWN);
    send_raw(FUNC_LEFT);
    send_raw(FUNC_UP);
    // load and a spare code while editing are ignored
    send_raw(FUNC_LOAD);
    send_raw(CODE_SPARE_LO);
    // day wraps at the month end both ways, then commit
    send_raw(FUNC_RIGHT);
    send_raw(FUNC_RIGHT);
    send_raw(FUNC_UP);
    send_raw(FUNC_DOWN);
    send_raw(FUNC_SET);

    // random part: mostly complete edit sessions, some loads and noise
    while (sent < COMMAND_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        if (in_edit) send_raw(FUNC_SET);
        if ($urandom_range(0, 3) == 0) send_raw(FUNC_LOAD);
        else send_load_in_range();
      end else if (pick < 9) begin
        if (!in_edit) begin
          if ($urandom_range(0, 1) == 0) send_load_in_range();
          send_raw(FUNC_SET);
        end
        n = $urandom_range(1, 40);
        repeat (n) send_raw(pick_edit_key());
        send_raw(FUNC_SET);
      end else begin
        send_raw(3'($urandom_range(0, 7)));
      end
    end
    cmd.valid <= 1'b0;

    // let the last predictions drain, then idle for DRAIN_CYCLES before the verdict
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("calendar_time_set_editor regression: pass");
    else
      $display("calendar_time_set_editor regression: fail");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/cte_pkg.sv
sv/cte_cmd_if.sv
sv/cte_status_if.sv
sv/calendar_time_set_editor.sv
sim/cte_edit_monitor.sv
sim/calendar_time_set_editor_test.sv
